[sv/rrss_pkg.sv]
// Shared types and constants of the round-robin slot scheduler.
// No dependencies; imported by the top, the slot controller and the checker.
package rrss_pkg;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SETRDY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Decision of the slot controller for one command.
  typedef struct packed {
    logic wr_en;       // enqueue placed: write handle to the table
    logic rd_en;       // pick found: read handle from the table
    logic went_idle;   // pick found no candidate
    logic table_full;  // enqueue found no free slot
  } rrss_ctl_t;

endpackage

[sv/round_robin_slot_scheduler.sv]
// Round-robin slot scheduler, top level. Depends on rrss_pkg, rrss_slot_ctrl, rrss_ram.
// Result: an item's fields are staged and its table read is issued at the accepting
// edge, then loaded into the output register once that register is free or drained.
// Flow: a new item waits until the last result loads; a held result stalls the next item's.
// Reset: rst_n (synchronous, low) clears used/ready marks, pointer, occupancy,
//   idle handle and valid flags at once; the handle table is not cleared.
module round_robin_slot_scheduler
  import rrss_pkg::*;
#(
  parameter int NUM_SLOTS   = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: idle handle
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HANDLE_W-1:0] cfg_data,
  // command items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [HANDLE_W-1:0] in_thread_handle,
  input  logic [SLOT_W-1:0]   in_target_slot,
  input  logic                in_ready_value,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_chosen_slot,
  output logic [HANDLE_W-1:0] out_chosen_handle,
  output logic                out_went_idle,
  output logic                out_table_full,
  output logic [COUNT_W-1:0]  out_used_count
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // Two-state sequencer: take an item, then wait for the table read and a free output register.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic                   state_r, state_nxt;
  logic [HANDLE_W-1:0]    idle_handle_r;
  logic                   accept;

  rrss_ctl_t              ctl;
  logic [IDX_W-1:0]       sel_idx;
  logic [CNT_W-1:0]       count_after;

  // Width adapters between the fixed port widths and the parameters.
  logic [HANDLE_BITS+HANDLE_W-1:0] in_handle_wide;
  logic [HANDLE_BITS-1:0]          store_handle;
  logic [HANDLE_BITS+HANDLE_W-1:0] enq_handle_wide;
  logic [HANDLE_BITS+HANDLE_W-1:0] ram_handle_wide;
  logic [IDX_W+SLOT_W-1:0]         slot_wide;
  logic [CNT_W+COUNT_W-1:0]        count_wide;
  logic [HANDLE_BITS-1:0]          ram_rdata;

  // Staged result, captured when the item is accepted.
  logic [SLOT_W-1:0]   stg_slot_r;
  logic [HANDLE_W-1:0] stg_handle_r;
  logic                stg_from_ram_r;
  logic                stg_idle_r;
  logic                stg_full_r;
  logic [COUNT_W-1:0]  stg_count_r;
  logic [HANDLE_W-1:0] stg_handle_nxt;

  // Output register.
  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_idle_r;
  logic                out_full_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_handle_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      idle_handle_r <= cfg_data;
    end
  end

  // Marks, pointer and occupancy advance at the accepting edge.
  rrss_slot_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (accept),
    .cmd         (in_cmd),
    .target_slot (in_target_slot),
    .ready_value (in_ready_value),
    .ctl         (ctl),
    .sel_idx     (sel_idx),
    .count_after (count_after)
  );

  assign in_handle_wide = {{HANDLE_BITS{1'b0}}, in_thread_handle};
  assign store_handle   = in_handle_wide[HANDLE_BITS-1:0];

  // Handle table: enqueue writes at accept, pick reads at accept and the
  // data arrives in the fill cycle. A later item is accepted only after the
  // fill state, so it never reads before a write lands; no forwarding path is needed.
  rrss_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_handle_ram (
    .clk   (clk),
    .we    (accept && ctl.wr_en),
    .waddr (sel_idx),
    .wdata (store_handle),
    .re    (accept && ctl.rd_en),
    .raddr (sel_idx),
    .rdata (ram_rdata)
  );

  assign enq_handle_wide = {{HANDLE_W{1'b0}}, store_handle};
  assign ram_handle_wide = {{HANDLE_W{1'b0}}, ram_rdata};
  assign slot_wide       = {{SLOT_W{1'b0}}, sel_idx};
  assign count_wide      = {{COUNT_W{1'b0}}, count_after};

  always_comb begin
    stg_handle_nxt = '0;
    if (ctl.wr_en) begin
      stg_handle_nxt = enq_handle_wide[HANDLE_W-1:0];
    end else if (ctl.went_idle) begin
      stg_handle_nxt = idle_handle_r;
    end
  end

  // Hold the staged fields while the result waits for the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_slot_r     <= slot_wide[SLOT_W-1:0];
      stg_handle_r   <= stg_handle_nxt;
      stg_from_ram_r <= ctl.rd_en;
      stg_idle_r     <= ctl.went_idle;
      stg_full_r     <= ctl.table_full;
      stg_count_r    <= count_wide[COUNT_W-1:0];
    end
  end

  // Load the output register once it is free or being drained.
  assign out_load = (state_r == ST_FILL) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r   <= stg_slot_r;
      out_handle_r <= stg_from_ram_r ? ram_handle_wide[HANDLE_W-1:0] : stg_handle_r;
      out_idle_r   <= stg_idle_r;
      out_full_r   <= stg_full_r;
      out_count_r  <= stg_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_slot   = out_slot_r;
  assign out_chosen_handle = out_handle_r;
  assign out_went_idle     = out_idle_r;
  assign out_table_full    = out_full_r;
  assign out_used_count    = out_count_r;

endmodule

[sv/rrss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rrss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/rrss_slot_ctrl.sv]
// Slot bookkeeping: used and ready marks, rotation pointer, occupancy,
// and the free-slot and round-robin searches. Depends on rrss_pkg.
module rrss_slot_ctrl
  import rrss_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             commit,
  input  logic [CMD_W-1:0]                 cmd,
  input  logic [SLOT_W-1:0]                target_slot,
  input  logic                             ready_value,
  output rrss_ctl_t                        ctl,
  output logic [$clog2(NUM_SLOTS)-1:0]     sel_idx,
  output logic [$clog2(NUM_SLOTS+1)-1:0]   count_after
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int TGT_W = IDX_W + SLOT_W;
  localparam logic [IDX_W:0]   NUM_L  = (IDX_W + 1)'(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_L = IDX_W'(NUM_SLOTS - 1);
  localparam logic [TGT_W-1:0] NUM_T  = TGT_W'(NUM_SLOTS);

  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] ready_r, ready_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;

  logic [NUM_SLOTS-1:0]   cand;
  logic [2*NUM_SLOTS-1:0] cand_dbl;
  logic [NUM_SLOTS-1:0]   cand_rot;
  logic                   pick_hit;
  logic [IDX_W-1:0]       pick_off;
  logic [IDX_W:0]         pick_sum;
  logic [IDX_W-1:0]       pick_idx;
  logic                   free_hit;
  logic [IDX_W-1:0]       free_idx;
  logic [TGT_W-1:0]       tgt_wide;
  logic                   tgt_ok;
  logic [IDX_W-1:0]       tgt_idx;

  // Lowest free slot.
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Rotate candidates so the pointer lands on bit 0, then find first set.
  assign cand     = used_r & ready_r;
  assign cand_dbl = {cand, cand};
  assign cand_rot = NUM_SLOTS'(cand_dbl >> ptr_r);

  always_comb begin
    pick_hit = 1'b0;
    pick_off = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cand_rot[i]) begin
        pick_hit = 1'b1;
        pick_off = IDX_W'(i);
      end
    end
  end

  always_comb begin
    pick_sum = {1'b0, ptr_r} + {1'b0, pick_off};
    if (pick_sum >= NUM_L) begin
      pick_sum = pick_sum - NUM_L;
    end
  end
  assign pick_idx = pick_sum[IDX_W-1:0];

  assign tgt_wide = {{IDX_W{1'b0}}, target_slot};
  assign tgt_ok   = tgt_wide < NUM_T;
  assign tgt_idx  = tgt_wide[IDX_W-1:0];

  always_comb begin
    ctl       = '0;
    sel_idx   = '0;
    used_nxt  = used_r;
    ready_nxt = ready_r;
    ptr_nxt   = ptr_r;
    occ_nxt   = occ_r;
    case (cmd)
      CMD_ENQ: begin
        if (free_hit) begin
          ctl.wr_en           = 1'b1;
          sel_idx             = free_idx;
          used_nxt[free_idx]  = 1'b1;
          ready_nxt[free_idx] = 1'b1;
          occ_nxt             = occ_r + CNT_W'(1);
        end else begin
          ctl.table_full = 1'b1;
        end
      end
      CMD_PICK: begin
        if (pick_hit) begin
          ctl.rd_en = 1'b1;
          sel_idx   = pick_idx;
          ptr_nxt   = (pick_idx == LAST_L) ? '0 : pick_idx + IDX_W'(1);
        end else begin
          ctl.went_idle = 1'b1;
        end
      end
      CMD_SETRDY: begin
        if (tgt_ok) begin
          ready_nxt[tgt_idx] = ready_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_after = occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      ready_r <= '0;
      ptr_r   <= '0;
      occ_r   <= '0;
    end else if (commit) begin
      used_r  <= used_nxt;
      ready_r <= ready_nxt;
      ptr_r   <= ptr_nxt;
      occ_r   <= occ_nxt;
    end
  end

endmodule

[sv/rrss_checker.sv]
// Port-level checks for the round-robin slot scheduler, bound to the top.
// Depends on rrss_pkg and round_robin_slot_scheduler.
module rrss_checker
  import rrss_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SLOT_W-1:0]   out_chosen_slot,
  input logic [HANDLE_W-1:0] out_chosen_handle,
  input logic                out_went_idle,
  input logic                out_table_full,
  input logic [COUNT_W-1:0]  out_used_count
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(NUM_SLOTS);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_slot)
      && $stable(out_chosen_handle) && $stable(out_used_count))
    else $error("stalled result changed");

  // A second item is never accepted back to back with the one before.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted back to back");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_went_idle |-> out_chosen_slot == '0 && !out_table_full)
    else $error("idle pick with slot or full flag set");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      out_chosen_slot == '0 && out_chosen_handle == '0
      && out_used_count == FULL_COUNT)
    else $error("full result inconsistent");

endmodule

bind round_robin_slot_scheduler rrss_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_rrss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_chosen_slot   (out_chosen_slot),
  .out_chosen_handle (out_chosen_handle),
  .out_went_idle     (out_went_idle),
  .out_table_full    (out_table_full),
  .out_used_count    (out_used_count)
);
